// File: design/keyword_signature_scanner_assert.svh
// Assertion macros shared by the scanner checker.
// Needs a clock named aclk and an active-low reset named aresetn in scope.
`ifndef KEYWORD_SIGNATURE_SCANNER_ASSERT_SVH
`define KEYWORD_SIGNATURE_SCANNER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define KSS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define KSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/kss_pkg.sv
// Package for the keyword and signature scanner: word types, rule codes,
// pattern constants and the ASCII fold function. No dependencies.
`default_nettype none

package kss_pkg;

    localparam int SIG_LEN    = 68;
    localparam int HIST_DEPTH = SIG_LEN - 1;
    localparam int POS_W      = 17;
    localparam int WINDOW_W   = 16;

    localparam logic [POS_W-1:0]    POS_MAX      = 17'd65536;
    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd16384;

    localparam int LEN_INITFAILED = 14;
    localparam int LEN_UTILS      = 9;
    localparam int LEN_NONPUBLIC  = 9;
    localparam int LEN_DOWNLOAD   = 14;
    localparam int LEN_BYPASS     = 6;
    localparam int KW_MAX_LEN     = 14;

    // Last character sits in the low byte, matching the window layout.
    localparam logic [SIG_LEN*8-1:0] SIG_TEXT =
        "X5O!P%@AP[4\\PZX54(P^)7CC)7}$EICAR-STANDARD-ANTIVIRUS-TEST-FILE!$H+H*";
    localparam logic [LEN_INITFAILED*8-1:0] KW_INITFAILED = "amsiinitfailed";
    localparam logic [LEN_UTILS*8-1:0]      KW_UTILS      = "amsiutils";
    localparam logic [LEN_NONPUBLIC*8-1:0]  KW_NONPUBLIC  = "nonpublic";
    localparam logic [LEN_DOWNLOAD*8-1:0]   KW_DOWNLOAD   = "downloadstring";
    localparam logic [LEN_BYPASS*8-1:0]     KW_BYPASS     = "bypass";

    localparam logic [7:0] ASCII_UPPER_A = 8'h41;
    localparam logic [7:0] ASCII_UPPER_Z = 8'h5a;
    localparam logic [7:0] ASCII_CASE    = 8'h20;

    typedef enum logic [1:0] {
        RULE_CLEAN     = 2'd0,
        RULE_SIGNATURE = 2'd1,
        RULE_KEYWORD   = 2'd2
    } rule_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } kss_in_t;

    typedef struct packed {
        logic  detected;
        rule_t rule_hit;
    } kss_out_t;

    typedef struct packed {
        logic signature;
        logic initfailed;
        logic utils;
        logic nonpublic;
        logic download;
        logic bypass;
    } kss_hits_t;

    // Fold A..Z to lower case; every other byte passes through.
    function automatic logic [7:0] fold_ascii(input logic [7:0] b);
        if (b >= ASCII_UPPER_A && b <= ASCII_UPPER_Z) begin
            return b + ASCII_CASE;
        end
        return b;
    endfunction

endpackage

`default_nettype wire

// File: design/kss_match.sv
// Parallel comparators: test every pattern against the byte window ending at
// the current byte. Depends on kss_pkg.
`default_nettype none

module kss_match (
    input  wire logic [kss_pkg::SIG_LEN*8-1:0] win,
    input  wire logic                          kw_en,
    output kss_pkg::kss_hits_t                 hits
);
    import kss_pkg::*;

    logic [KW_MAX_LEN*8-1:0] fold_win;

    always_comb begin
        for (int j = 0; j < KW_MAX_LEN; j++) begin
            fold_win[j*8 +: 8] = fold_ascii(win[j*8 +: 8]);
        end
    end

    always_comb begin
        hits.signature  = (win == SIG_TEXT);
        hits.initfailed = kw_en && (fold_win[LEN_INITFAILED*8-1:0] == KW_INITFAILED);
        hits.utils      = kw_en && (fold_win[LEN_UTILS*8-1:0] == KW_UTILS);
        hits.nonpublic  = kw_en && (fold_win[LEN_NONPUBLIC*8-1:0] == KW_NONPUBLIC);
        hits.download   = kw_en && (fold_win[LEN_DOWNLOAD*8-1:0] == KW_DOWNLOAD);
        hits.bypass     = kw_en && (fold_win[LEN_BYPASS*8-1:0] == KW_BYPASS);
    end

endmodule

`default_nettype wire

// File: design/kss_state.sv
// Per-message state: byte history shift line, position count and rule flags,
// plus the verdict for the word in process. Depends on kss_pkg, kss_match.
`default_nettype none

module kss_state (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            advance,
    input  wire kss_pkg::kss_in_t                in_word,
    input  wire logic [kss_pkg::WINDOW_W-1:0]    window,
    output kss_pkg::kss_out_t                    verdict
);
    import kss_pkg::*;

    logic [7:0]           hist_reg [HIST_DEPTH];
    logic [POS_W-1:0]     pos_reg;
    kss_hits_t            seen_reg;
    kss_hits_t            seen_next;
    kss_hits_t            hits;
    logic [SIG_LEN*8-1:0] win;
    logic                 kw_en;
    logic                 kw_rule;

    // Current byte in the low byte, oldest history byte on top.
    always_comb begin
        win[7:0] = in_word.data_byte;
        for (int j = 0; j < HIST_DEPTH; j++) begin
            win[(j+1)*8 +: 8] = hist_reg[j];
        end
    end

    assign kw_en = pos_reg < {1'b0, window};

    kss_match u_match (
        .win   (win),
        .kw_en (kw_en),
        .hits  (hits)
    );

    assign seen_next = seen_reg | hits;
    assign kw_rule   = seen_next.initfailed
                    || (seen_next.utils && seen_next.nonpublic)
                    || (seen_next.download && seen_next.bypass);

    always_comb begin
        if (seen_next.signature) begin
            verdict.rule_hit = RULE_SIGNATURE;
        end else if (kw_rule) begin
            verdict.rule_hit = RULE_KEYWORD;
        end else begin
            verdict.rule_hit = RULE_CLEAN;
        end
        verdict.detected = seen_next.signature || kw_rule;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (advance && in_word.last_byte)) begin
            for (int j = 0; j < HIST_DEPTH; j++) begin
                hist_reg[j] <= '0;
            end
            pos_reg  <= '0;
            seen_reg <= '0;
        end else if (advance) begin
            hist_reg[0] <= in_word.data_byte;
            for (int j = 1; j < HIST_DEPTH; j++) begin
                hist_reg[j] <= hist_reg[j-1];
            end
            if (pos_reg != POS_MAX) begin
                pos_reg <= pos_reg + 1'b1;
            end
            seen_reg <= seen_next;
        end
    end

endmodule

`default_nettype wire

// File: design/keyword_signature_scanner.sv
// Path: a last byte waits in the input register, passes the combinational compare and
// loads the result register that drives m_valid; a waiting verdict can hold it first.
// Throughput: one byte per cycle while no last byte waits on an occupied verdict slot;
// the 67-byte history line and parallel comparators finish each byte in a single pass.
// Reset (aresetn low, synchronous): clear history, position count, flags and the valid
// bits of both registers, load keyword_window with 16384.
`default_nettype none

module keyword_signature_scanner (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // configuration: keyword_window
    input  wire logic                          cfg_wr_en,
    input  wire logic [kss_pkg::WINDOW_W-1:0]  cfg_wr_data,
    // input byte stream
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire kss_pkg::kss_in_t              s_word,
    // verdict stream, one word per message
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output kss_pkg::kss_out_t                  m_word
);
    import kss_pkg::*;

    logic                in_vld_reg;
    kss_in_t             in_word_reg;
    logic                out_vld_reg;
    kss_out_t            out_word_reg;
    logic [WINDOW_W-1:0] window_reg;
    logic                advance;
    kss_out_t            verdict;

    // Advance the held byte unless it is a last byte and the verdict slot is
    // still occupied. Bytes that are not last produce no word, so they never
    // wait on the output side.
    assign advance = in_vld_reg
                  && (!in_word_reg.last_byte || !out_vld_reg || m_ready);

    // Take a new byte whenever the input register empties this cycle.
    assign s_ready = !in_vld_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= WINDOW_RESET;
        end else if (cfg_wr_en) begin
            window_reg <= cfg_wr_data;
        end
    end

    // Input register: hold the byte until the compare pass consumes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_valid && s_ready) begin
            in_vld_reg <= 1'b1;
        end else if (advance) begin
            in_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_word_reg <= s_word;
        end
    end

    kss_state u_state (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .in_word (in_word_reg),
        .window  (window_reg),
        .verdict (verdict)
    );

    // Result register: load the verdict on a last byte, drop it once taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (advance && in_word_reg.last_byte) begin
            out_vld_reg <= 1'b1;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_word_reg.last_byte) begin
            out_word_reg <= verdict;
        end
    end

    assign m_valid = out_vld_reg;
    assign m_word  = out_word_reg;

endmodule

`default_nettype wire

// File: design/kss_checker.sv
// Port-level checks for the scanner, bound to the top level.
// Depends on kss_pkg and keyword_signature_scanner_assert.svh.
`default_nettype none
`include "keyword_signature_scanner_assert.svh"

module kss_checker (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    input  wire logic              s_ready,
    input  wire kss_pkg::kss_in_t  s_word,
    input  wire logic              m_valid,
    input  wire logic              m_ready,
    input  wire kss_pkg::kss_out_t m_word
);
    import kss_pkg::*;

    logic in_fire;
    assign in_fire = s_valid && s_ready && s_word.last_byte;

    // A stalled verdict holds.
    `KSS_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_word), "verdict changed while stalled")

    // Detected flag agrees with the rule code.
    `KSS_ASSERT_NOW(a_detect_code, m_valid, m_word.detected == (m_word.rule_hit != RULE_CLEAN), "detected disagrees with rule_hit")

    // Input backpressure only comes from a waiting verdict.
    `KSS_ASSERT_NOW(a_stall_cause, !s_ready, m_valid, "input stalled with no verdict pending")

    // A last byte taken while no verdict waits leaves the input ready or a verdict valid in the cycle after.
    `KSS_ASSERT_NEXT(a_last_fill, in_fire && !m_valid, s_ready || m_valid, "last byte lost in pipeline")

endmodule

bind keyword_signature_scanner kss_checker u_kss_checker (.*);

`default_nettype wire

// File: tb/tb.sv
// Self-checking testbench for keyword_signature_scanner: streams messages one byte per
// word, predicts each verdict in a small scoreboard class and checks the result channel.
// Depends on kss_pkg (word types, rule codes, widths) and the scanner RTL.

module tb;
    import kss_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 7;
    localparam int HISTORY_BYTES  = 67;
    localparam int NUM_KEYWORDS   = 5;
    localparam int SETTLE_CYCLES  = 4;          // idle time after the last verdict is checked
    localparam int HOLD_CYCLES    = 300;        // long receiver hold-off
    localparam int PHASE_BYTES    = 150;        // least random bytes per window setting
    localparam int NUM_PHASES     = 8;
    localparam int PRESSURE_MSGS  = 40;
    localparam int TIMEOUT_CYCLES = 1_000_000;

    localparam logic [16:0] POS_LIMIT       = 17'd65536;
    localparam logic [15:0] WINDOW_AT_RESET = 16'd16384;
    localparam logic [15:0] WINDOW_FULL     = 16'hFFFF;
    localparam logic [7:0]  CASE_BIT        = 8'h20;
    localparam logic [7:0]  HIGH_BIT        = 8'h80;

    typedef enum int {
        KW_INITFAILED = 0,
        KW_UTILS      = 1,
        KW_NONPUBLIC  = 2,
        KW_DOWNLOAD   = 3,
        KW_BYPASS     = 4
    } keyword_e;

    // Tracks one message at a time and queues the verdict each last byte should produce.
    class verdict_scoreboard;
        string      sig_text;
        string      keywords [NUM_KEYWORDS];
        logic [7:0] history [HISTORY_BYTES];
        logic [16:0] byte_pos;
        logic [15:0] window;
        bit         sig_seen;
        bit         kw_seen [NUM_KEYWORDS];
        kss_out_t   verdicts_due [$];
        int         errors;
        int         bytes_seen;
        int         checked;
        int         rule_count [3];

        function new();
            sig_text = "X5O!P%@AP[4\\PZX54(P^)7CC)7}$EICAR-STANDARD-ANTIVIRUS-TEST-FILE!$H+H*";
            keywords[KW_INITFAILED] = "amsiinitfailed";
            keywords[KW_UTILS]      = "amsiutils";
            keywords[KW_NONPUBLIC]  = "nonpublic";
            keywords[KW_DOWNLOAD]   = "downloadstring";
            keywords[KW_BYPASS]     = "bypass";
            window     = WINDOW_AT_RESET;
            errors     = 0;
            bytes_seen = 0;
            checked    = 0;
            foreach (rule_count[k]) rule_count[k] = 0;
            clear_message();
        endfunction

        function void clear_message();
            foreach (history[k]) history[k] = 8'h00;
            foreach (kw_seen[k]) kw_seen[k] = 1'b0;
            byte_pos = '0;
            sig_seen = 1'b0;
        endfunction

        function logic [7:0] lower(logic [7:0] b);
            if (b >= "A" && b <= "Z") begin
                return b + CASE_BIT;
            end
            return b;
        endfunction

        // True if pat ends with cur, the earlier characters sitting in the history.
        function bit ends_at(string pat, logic [7:0] cur, bit fold);
            int n;
            logic [7:0] h;
            n = pat.len();
            if ((fold ? lower(cur) : cur) != 8'(pat[n-1])) begin
                return 1'b0;
            end
            for (int k = 0; k + 1 < n; k++) begin
                h = fold ? lower(history[k]) : history[k];
                if (h != 8'(pat[n-2-k])) begin
                    return 1'b0;
                end
            end
            return 1'b1;
        endfunction

        function void note_byte(kss_in_t w);
            kss_out_t due;
            rule_t    rule;
            bit       kw_rule;
            bytes_seen++;
            if (ends_at(sig_text, w.data_byte, 1'b0)) begin
                sig_seen = 1'b1;
            end
            if (byte_pos < {1'b0, window}) begin
                foreach (keywords[k]) begin
                    if (ends_at(keywords[k], w.data_byte, 1'b1)) kw_seen[k] = 1'b1;
                end
            end
            for (int k = HISTORY_BYTES - 1; k > 0; k--) history[k] = history[k-1];
            history[0] = w.data_byte;
            if (byte_pos < POS_LIMIT) begin
                byte_pos++;
            end
            if (w.last_byte) begin
                kw_rule = kw_seen[KW_INITFAILED]
                       || (kw_seen[KW_UTILS] && kw_seen[KW_NONPUBLIC])
                       || (kw_seen[KW_DOWNLOAD] && kw_seen[KW_BYPASS]);
                rule = sig_seen ? RULE_SIGNATURE : (kw_rule ? RULE_KEYWORD : RULE_CLEAN);
                due.detected = (rule != RULE_CLEAN);
                due.rule_hit = rule;
                verdicts_due.push_back(due);
                clear_message();
            end
        endfunction

        function void check_verdict(kss_out_t got);
            kss_out_t want;
            checked++;
            if (verdicts_due.size() == 0) begin
                $error("verdict with no message pending: detected %0d rule_hit %0d",
                       got.detected, got.rule_hit);
                errors++;
                return;
            end
            want = verdicts_due.pop_front();
            rule_count[int'(want.rule_hit)]++;
            if (got.detected !== want.detected) begin
                $error("detected: expected %0d, got %0d", want.detected, got.detected);
                errors++;
            end
            if (got.rule_hit !== want.rule_hit) begin
                $error("rule_hit: expected %0d, got %0d", want.rule_hit, got.rule_hit);
                errors++;
            end
        endfunction
    endclass

    logic                aclk        = 1'b0;
    logic                aresetn     = 1'b0;
    logic                cfg_wr_en   = 1'b0;
    logic [WINDOW_W-1:0] cfg_wr_data = '0;
    logic                s_valid     = 1'b0;
    logic                s_ready;
    kss_in_t             s_word      = '0;
    logic                m_valid;
    logic                m_ready     = 1'b0;
    kss_out_t            m_word;

    bit         calm     = 1'b0;    // no idling on either side while set
    bit         hold_req = 1'b0;    // ask the receiver for one long hold-off
    int         input_stalls  = 0;
    int         window_writes = 0;
    logic [7:0] msg [$];            // message being built, sent front to back

    verdict_scoreboard sb = new();

    keyword_signature_scanner dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_word      (s_word),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_word      (m_word)
    );

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    // Sample both handshakes at the edge; predict on every accepted byte, check every verdict.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) sb.note_byte(s_word);
            if (m_valid && m_ready) sb.check_verdict(m_word);
            if (s_valid && !s_ready) input_stalls++;
        end
    end

    // Receiver: drop ready about 15 percent of the time, hold it low for a long stretch on request.
    initial begin
        int held;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                for (held = 0; held < HOLD_CYCLES; held++) @(posedge aclk);
                hold_req = 1'b0;
                m_ready <= 1'b1;
            end else if (calm) begin
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(99) >= 15);
            end
        end
    end

    // Offer one word and hold it until accepted; sometimes idle first.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int gap;
        if (!calm && $urandom_range(99) < 15) begin
            gap = $urandom_range(1, 3);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_word  <= '{data_byte: b, last_byte: last};
        do @(posedge aclk); while (s_ready !== 1'b1);
    endtask

    task automatic send_message();
        foreach (msg[i]) send_byte(msg[i], i == msg.size() - 1);
    endtask

    // Drop valid, wait for every verdict, then let the pipeline settle.
    task automatic wait_quiet();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.verdicts_due.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Only called with the block idle, so the new window covers whole messages.
    task automatic write_window(input logic [15:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        sb.window = value;
        window_writes++;
        cfg_wr_en <= 1'b0;
    endtask

    function automatic void push_text(string t, bit random_case);
        logic [7:0] c;
        for (int i = 0; i < t.len(); i++) begin
            c = t[i];
            if (random_case && c >= "a" && c <= "z" && $urandom_range(1) == 1) c = c - CASE_BIT;
            msg.push_back(c);
        end
    endfunction

    function automatic void push_filler(int n, bit letters);
        logic [7:0] c;
        repeat (n) begin
            c = letters ? 8'($urandom_range("a", "z")) : 8'($urandom_range(0, 255));
            if (letters && $urandom_range(1) == 1) c = c - CASE_BIT;
            msg.push_back(c);
        end
    endfunction

    // Break one of the last len bytes: a high-bit twin, a case flip or any byte.
    function automatic void mangle_recent(int len);
        int idx;
        int roll;
        idx  = msg.size() - 1 - $urandom_range(len - 1);
        roll = $urandom_range(2);
        if (roll == 0) begin
            msg[idx] = msg[idx] ^ HIGH_BIT;
        end else if (roll == 1) begin
            msg[idx] = msg[idx] ^ CASE_BIT;
        end else begin
            msg[idx] = 8'($urandom_range(0, 255));
        end
    endfunction

    function automatic keyword_e partner_of(keyword_e k);
        case (k)
            KW_UTILS:     return KW_NONPUBLIC;
            KW_NONPUBLIC: return KW_UTILS;
            KW_DOWNLOAD:  return KW_BYPASS;
            KW_BYPASS:    return KW_DOWNLOAD;
            default:      return KW_INITFAILED;
        endcase
    endfunction

    // Mostly keywords in random case and the test string, with near misses,
    // prefixes and noise in between.
    function automatic void build_message();
        int       parts;
        int       roll;
        keyword_e pick;
        string    t;
        msg.delete();
        parts = $urandom_range(1, 4);
        repeat (parts) begin
            roll = $urandom_range(99);
            pick = keyword_e'($urandom_range(NUM_KEYWORDS - 1));
            t    = sb.keywords[pick];
            if (roll < 20) begin
                push_filler($urandom_range(0, 6), 1'b0);
            end else if (roll < 30) begin
                push_filler($urandom_range(1, 6), 1'b1);
            end else if (roll < 72) begin
                push_text(t, 1'b1);
                if ($urandom_range(99) < 25) mangle_recent(t.len());
                if (pick != KW_INITFAILED && $urandom_range(99) < 50) begin
                    push_text(sb.keywords[partner_of(pick)], 1'b1);
                end
            end else if (roll < 80) begin
                push_text(sb.sig_text, 1'b0);
                if ($urandom_range(99) < 30) mangle_recent(sb.sig_text.len());
            end else if (roll < 90) begin
                push_text(t.substr(0, $urandom_range(0, t.len() - 2)), 1'b1);
            end else begin
                msg.push_back(8'($urandom_range(0, 255)));
            end
        end
        if (msg.size() == 0) msg.push_back(8'($urandom_range(0, 255)));
    endfunction

    initial begin
        int unsigned phase_window [NUM_PHASES];
        int          sent;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: extreme bytes as one-byte messages, a folded keyword alone,
        // a half pair, and a high-bit byte next to an ASCII byte.
        msg.delete(); msg.push_back(8'h00);                   send_message();
        msg.delete(); msg.push_back(8'hFF);                   send_message();
        msg.delete(); push_text("AMSIINITFAILED", 1'b0);      send_message();
        msg.delete(); push_text("bypass", 1'b0);              send_message();
        msg.delete(); msg.push_back(8'hC1); msg.push_back(8'h7F); send_message();
        wait_quiet();

        // Random messages under several windows: reset value, zero, the keyword-length
        // edges, one, the maximum, nine and a small random one.
        phase_window = '{WINDOW_AT_RESET, 0, 13, 14, 1, WINDOW_FULL, 9,
                         $urandom_range(2, 60)};
        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p > 0) write_window(16'(phase_window[p]));
            calm = (p == 3);
            sent = 0;
            while (sent < PHASE_BYTES) begin
                build_message();
                send_message();
                sent += msg.size();
            end
            wait_quiet();
        end
        calm = 1'b0;

        // Back-pressure: hold the receiver off while short messages keep coming,
        // so a verdict waits and the input stalls.
        hold_req = 1'b1;
        repeat (PRESSURE_MSGS) begin
            msg.delete();
            push_filler($urandom_range(1, 2), 1'($urandom_range(1)));
            send_message();
        end
        wait_quiet();

        $display("Scanned %0d bytes and checked %0d verdicts: %0d clean, %0d test string, %0d keyword.",
                 sb.bytes_seen, sb.checked, sb.rule_count[RULE_CLEAN],
                 sb.rule_count[RULE_SIGNATURE], sb.rule_count[RULE_KEYWORD]);
        $display("Window written %0d times from 0 to 65535; input stalled for %0d cycles.",
                 window_writes, input_stalls);
        if (sb.errors == 0) begin
            $display("keyword_signature_scanner: match");
        end else begin
            $display("keyword_signature_scanner: mismatch");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #(TIMEOUT_CYCLES * 2 * CLK_HALF);
        $display("keyword_signature_scanner: mismatch");
        $finish;
    end

endmodule
